// ===== design/sdiv_pkg.sv =====
// Package for the signed 8-bit restoring divider: stage payload type,
// status codes and the single restoring step shared by the step stages.
// No dependencies.
`default_nettype none

package sdiv_pkg;

    localparam int unsigned DATA_W         = 8;
    localparam int unsigned STEP_STAGES    = 4;
    localparam int unsigned BITS_PER_STAGE = DATA_W / STEP_STAGES;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Payload carried stage to stage.
    typedef struct packed {
        logic [DATA_W-1:0] num;       // dividend magnitude bits not yet consumed, MSB first
        logic [DATA_W:0]   part;      // partial remainder
        logic [DATA_W-1:0] quo;       // quotient bits so far
        logic [DATA_W-1:0] den;       // divisor magnitude
        logic              neg_a;
        logic              neg_b;
        logic [DATA_W-1:0] dividend;  // raw dividend, for the divide-by-zero result
        logic              div_zero;
        logic              ovf;
    } sdiv_work_t;

    // One restoring step: shift in a dividend bit, trial subtract, restore on borrow.
    function automatic sdiv_work_t div_step(input sdiv_work_t w);
        sdiv_work_t        r;
        logic [DATA_W:0]   shifted;
        logic [DATA_W+1:0] diff;
        r       = w;
        shifted = {w.part[DATA_W-1:0], w.num[DATA_W-1]};
        r.num   = {w.num[DATA_W-2:0], 1'b0};
        diff    = {1'b0, shifted} - {2'b00, w.den};
        if (!diff[DATA_W+1]) begin
            r.part = diff[DATA_W:0];
            r.quo  = {w.quo[DATA_W-2:0], 1'b1};
        end else begin
            r.part = shifted;
            r.quo  = {w.quo[DATA_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/signed_restoring_divider_8bit.sv =====
// Signed 8-bit restoring divider, fully pipelined. One operand pair is accepted
// per cycle unless the result side stalls. There are six register stages: one input
// stage, four stages of two restoring steps each, and one sign/result stage. Each
// result passes through all six in that order before m_tvalid rises for it.
// Results come out in input order. Every stage holds its own valid bit and loads
// whenever it is empty or its successor takes its item. A stall on the result side
// therefore only backs up as far as the pipeline is full, and bubbles are squeezed out.
// Quotient truncates toward zero, remainder takes the dividend's sign.
// Divide by zero: quotient 0xFF, remainder = dividend, status 1.
// -128 / -1: quotient wraps to -128, remainder 0, status 2. Otherwise status 0.
// Depends on sdiv_pkg, sdiv_pre, sdiv_step, sdiv_post.
`default_nettype none

module signed_restoring_divider_8bit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] dividend, [15:8] divisor
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [7:0] quotient, [15:8] remainder, [17:16] status
);
    import sdiv_pkg::*;

    // stage handshakes: index 0 is the input stage output, index STEP_STAGES the last step
    logic       valid_w [STEP_STAGES+1];
    logic       ready_w [STEP_STAGES+1];
    sdiv_work_t work_w  [STEP_STAGES+1];

    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic [1:0]        status;

    sdiv_pre u_pre (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_dividend(s_tdata[DATA_W-1:0]),
        .in_divisor (s_tdata[2*DATA_W-1:DATA_W]),
        .out_valid  (valid_w[0]),
        .out_ready  (ready_w[0]),
        .out_work   (work_w[0])
    );

    // restoring steps, BITS_PER_STAGE per register stage
    for (genvar g = 0; g < STEP_STAGES; g++) begin : g_step
        sdiv_step u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (valid_w[g]),
            .in_ready (ready_w[g]),
            .in_work  (work_w[g]),
            .out_valid(valid_w[g+1]),
            .out_ready(ready_w[g+1]),
            .out_work (work_w[g+1])
        );
    end

    sdiv_post u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (valid_w[STEP_STAGES]),
        .in_ready     (ready_w[STEP_STAGES]),
        .in_work      (work_w[STEP_STAGES]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_quotient (quotient),
        .out_remainder(remainder),
        .out_status   (status)
    );

    // pad to whole bytes
    assign m_tdata = {6'b0, status, remainder, quotient};

endmodule

`default_nettype wire

// ===== design/sdiv_pre.sv =====
// Input stage of the signed divider: operand magnitudes, sign and special-case flags.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_pre (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [sdiv_pkg::DATA_W-1:0] in_dividend,
    input  wire logic [sdiv_pkg::DATA_W-1:0] in_divisor,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output sdiv_pkg::sdiv_work_t          out_work
);
    import sdiv_pkg::*;

    logic       valid_reg;
    sdiv_work_t work_reg;
    sdiv_work_t work_next;
    logic       neg_a;
    logic       neg_b;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    assign neg_a = in_dividend[DATA_W-1];
    assign neg_b = in_divisor[DATA_W-1];

    always_comb begin
        work_next.num      = neg_a ? (DATA_W'(0) - in_dividend) : in_dividend;
        work_next.part     = '0;
        work_next.quo      = '0;
        work_next.den      = neg_b ? (DATA_W'(0) - in_divisor) : in_divisor;
        work_next.neg_a    = neg_a;
        work_next.neg_b    = neg_b;
        work_next.dividend = in_dividend;
        work_next.div_zero = (in_divisor == '0);
        // most negative over minus one
        work_next.ovf      = (in_dividend == {1'b1, {(DATA_W-1){1'b0}}})
                             && (in_divisor == '1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/sdiv_step.sv =====
// One divider pipeline stage: BITS_PER_STAGE restoring steps, then a register.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_step (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sdiv_pkg::sdiv_work_t in_work,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sdiv_pkg::sdiv_work_t      out_work
);
    import sdiv_pkg::*;

    logic       valid_reg;
    sdiv_work_t work_reg;
    sdiv_work_t work_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_comb begin
        work_next = in_work;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            work_next = div_step(work_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/sdiv_post.sv =====
// Output stage of the signed divider: sign correction, special cases, result register.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_post (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire sdiv_pkg::sdiv_work_t     in_work,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [sdiv_pkg::DATA_W-1:0]   out_quotient,
    output logic [sdiv_pkg::DATA_W-1:0]   out_remainder,
    output logic [1:0]                    out_status
);
    import sdiv_pkg::*;

    logic              valid_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [1:0]        status_reg;
    logic [DATA_W-1:0] quo_next;
    logic [DATA_W-1:0] rem_next;
    logic [1:0]        status_next;
    logic [DATA_W-1:0] rem_mag;

    assign in_ready      = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign out_quotient  = quo_reg;
    assign out_remainder = rem_reg;
    assign out_status    = status_reg;

    assign rem_mag = in_work.part[DATA_W-1:0];

    always_comb begin
        if (in_work.div_zero) begin
            quo_next    = '1;
            rem_next    = in_work.dividend;
            status_next = STATUS_DIV_ZERO;
        end else begin
            quo_next    = (in_work.neg_a ^ in_work.neg_b) ? (DATA_W'(0) - in_work.quo)
                                                          : in_work.quo;
            rem_next    = in_work.neg_a ? (DATA_W'(0) - rem_mag) : rem_mag;
            status_next = in_work.ovf ? STATUS_OVERFLOW : STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            quo_reg    <= quo_next;
            rem_reg    <= rem_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== dv/signed_restoring_divider_8bit_tb.sv =====
// Self-checking testbench for signed_restoring_divider_8bit: directed corner operands, then
// random pairs with random stalls on both stream sides, checked against a local division model.
// Depends on sdiv_pkg and signed_restoring_divider_8bit.
`timescale 1ns / 1ps

module signed_restoring_divider_8bit_tb;

    import sdiv_pkg::*;

    localparam int RANDOM_PAIRS   = 400;
    localparam int HOLD_AT_COUNT  = 100;  // long receiver hold-off starts here
    localparam int HOLD_CYCLES    = 80;
    localparam int CALM_TAIL      = 60;   // last transfers run without idling
    localparam int IDLE_LIMIT     = 2000; // cycles without any transfer
    localparam int TAIL_CYCLES    = 12;   // pipeline is six deep

    typedef struct {
        logic [7:0] dividend;
        logic [7:0] divisor;
        bit         drain_first;  // wait for all results before offering this pair
    } operand_pair_t;

    typedef struct {
        logic [7:0] quotient;
        logic [7:0] remainder;
        logic [1:0] status;
    } div_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;   // [7:0] dividend, [15:8] divisor
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;         // [7:0] quotient, [15:8] remainder, [17:16] status

    operand_pair_t pending_pairs[$];
    div_result_t   expected_quotients[$];

    int  total_pairs    = 0;
    int  accepted_pairs = 0;
    int  error_count    = 0;
    int  idle_cycles    = 0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    bit  pair_taken     = 1'b0;

    signed_restoring_divider_8bit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Truncating signed division over 9-bit magnitudes, one restoring step per bit.
    function automatic div_result_t predict_division(logic [7:0] dividend, logic [7:0] divisor);
        div_result_t res;
        logic [8:0]  mag_n;
        logic [8:0]  mag_d;
        logic [8:0]  rem;
        logic [7:0]  quo;
        logic        sign_n;
        logic        sign_d;
        sign_n = dividend[7];
        sign_d = divisor[7];
        if (divisor == 8'h00) begin
            res.quotient  = 8'hFF;
            res.remainder = dividend;
            res.status    = STATUS_DIV_ZERO;
            return res;
        end
        mag_n = sign_n ? 9'd256 - {1'b0, dividend} : {1'b0, dividend};
        mag_d = sign_d ? 9'd256 - {1'b0, divisor} : {1'b0, divisor};
        rem   = '0;
        quo   = '0;
        // magnitude of -128 is 0x080, so bits 7..0 hold the whole dividend
        for (int i = 7; i >= 0; i--) begin
            rem = {rem[7:0], mag_n[i]};
            quo = {quo[6:0], 1'b0};
            if (rem >= mag_d) begin
                rem    = rem - mag_d;
                quo[0] = 1'b1;
            end
        end
        res.quotient  = (sign_n != sign_d) ? 8'd0 - quo : quo;
        res.remainder = sign_n ? 8'd0 - rem[7:0] : rem[7:0];
        res.status    = (dividend == 8'h80 && divisor == 8'hFF) ? STATUS_OVERFLOW : STATUS_OK;
        return res;
    endfunction

    task automatic report_mismatch(string field, int expected_val, int got_val);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, expected_val,
                 got_val);
        error_count++;
    endtask

    task automatic add_pair(int dividend, int divisor, bit drain_first);
        operand_pair_t p;
        p.dividend    = dividend[7:0];
        p.divisor     = divisor[7:0];
        p.drain_first = drain_first;
        pending_pairs.push_back(p);
    endtask

    // Random idling is off in the tail and in every fourth window of 64 transfers.
    function automatic bit idling_allowed();
        return (accepted_pairs < total_pairs - CALM_TAIL) && ((accepted_pairs / 64) % 4 != 3);
    endfunction

    function automatic logic [7:0] corner_operand();
        case ($urandom_range(0, 5))
            0: return 8'h80;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h01;
            4: return 8'h81;
            default: return 8'h00;
        endcase
    endfunction

    // Sender: updates at the falling edge; a transfer seen at the last rising edge frees it.
    always @(negedge aclk) begin
        logic        valid_next;
        logic [15:0] data_next;
        valid_next = s_tvalid;
        data_next  = s_tdata;
        if (valid_next && pair_taken)
            valid_next = 1'b0;
        pair_taken = 1'b0;
        if (aresetn && !valid_next) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_pairs.size() > 0) begin
                if (pending_pairs[0].drain_first && expected_quotients.size() != 0) begin
                    // hold back until the pipeline has emptied
                end else if (idling_allowed() && hold_left == 0 && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 7);  // start an idle burst of random length
                end else begin
                    data_next  = {pending_pairs[0].divisor, pending_pairs[0].dividend};
                    valid_next = 1'b1;
                    void'(pending_pairs.pop_front());
                end
            end
        end
        s_tvalid <= valid_next;
        s_tdata  <= data_next;
    end

    // Receiver: random stall bursts plus one long hold-off to back the pipeline up.
    always @(negedge aclk) begin
        logic ready_next;
        ready_next = 1'b1;
        if (!aresetn) begin
            ready_next = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else if (!hold_done && accepted_pairs >= HOLD_AT_COUNT) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            ready_next = 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            ready_next = 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
            recv_gap   = $urandom_range(0, 7);
            ready_next = 1'b0;
        end
        m_tready <= ready_next;
    end

    // Input side: each accepted transfer queues its predicted result.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_quotients.push_back(predict_division(s_tdata[7:0], s_tdata[15:8]));
            accepted_pairs++;
            pair_taken = 1'b1;
        end
    end

    // Result side: compare every transfer with the oldest expectation.
    always @(posedge aclk) begin
        div_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_quotients.size() == 0) begin
                $display("[%0t] result transfer with nothing expected, data %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_quotients.pop_front();
                if (m_tdata[7:0] !== want.quotient)
                    report_mismatch("quotient", want.quotient, m_tdata[7:0]);
                if (m_tdata[15:8] !== want.remainder)
                    report_mismatch("remainder", want.remainder, m_tdata[15:8]);
                if (m_tdata[17:16] !== want.status)
                    report_mismatch("status", want.status, m_tdata[17:16]);
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // Directed: zero divisors, most negative operands, all sign combinations.
        add_pair(5, 0, 1'b0);
        add_pair(-128, 0, 1'b0);
        add_pair(127, 0, 1'b0);
        add_pair(0, 0, 1'b0);
        add_pair(-128, -1, 1'b0);
        add_pair(-128, 1, 1'b0);
        add_pair(-128, -128, 1'b0);
        add_pair(127, -128, 1'b0);
        add_pair(-128, 127, 1'b0);
        add_pair(127, 127, 1'b0);
        add_pair(-1, -128, 1'b0);
        add_pair(7, 2, 1'b0);
        add_pair(-7, 2, 1'b0);
        add_pair(7, -2, 1'b0);
        add_pair(-7, -2, 1'b0);
        add_pair(0, 5, 1'b0);
        add_pair(1, -1, 1'b0);
        add_pair(127, 1, 1'b0);
        add_pair(-127, -1, 1'b0);
        add_pair(100, -3, 1'b0);
        add_pair(-100, 7, 1'b0);
        add_pair(0, -128, 1'b0);
        add_pair(-1, 1, 1'b0);
        add_pair(127, -1, 1'b0);
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            operand_pair_t p;
            p.dividend    = $urandom_range(0, 255);
            p.divisor     = $urandom_range(0, 255);
            // pause the sender until the pipeline drains, after directed and mid-run
            p.drain_first = (n == 0) || (n == RANDOM_PAIRS / 2);
            case ($urandom_range(0, 9))
                0: p.divisor = 8'h00;
                1: p.dividend = corner_operand();
                2: p.divisor = corner_operand();
                default: ;
            endcase
            pending_pairs.push_back(p);
        end
        total_pairs = pending_pairs.size();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (accepted_pairs < total_pairs || expected_quotients.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
